>>> hdl/fwbp_pkg.sv
package fwbp_pkg;

   // Fixed widths of the data path.
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned PosWidth   = 5;
   localparam int unsigned FieldBits  = 6;
   localparam int unsigned CsrIdxBits = 1;

   typedef logic [CsrIdxBits-1:0] csr_index_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CsrFieldWidth = 1'b0;
   localparam csr_index_type CsrTotalCount = 1'b1;

   typedef struct packed {
      logic [WordWidth-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [WordWidth-1:0] word;
      logic                 is_tail;
      logic                 group_end;
   } rsp_payload_type;

endpackage

>>> hdl/fwbp_stream_if.sv
interface fwbp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/fixed_width_bit_packer_core.sv
// Fixed-width bit packer.
// Values arrive one per transaction on req_chan. Each is masked to the configured
// field width and appended, LSB first, into a 32-bit accumulator; every filled
// word leaves as one transaction on rsp_chan. The 32nd value of each group of 32
// flushes the accumulator with group_end set. Values past the last full group
// within total_count leave unchanged with is_tail set; values past total_count
// are dropped.
// Configuration is written through csr_write_enable, csr_index and csr_write_data;
// the user must do so only while the block is idle; the block does not enforce it.
// A value is registered at the input, then packed into the result register. One
// value is taken every cycle unless the receiver stalls; the accumulator update
// is a single shift and OR.
// Synchronous reset empties both stages, clears the packing state and sets the
// field width to 32 and the total count to 0.
// When the receiver stalls, the result register holds its transaction and the
// input register fills; req_chan.ready then drops until the result is taken.
module fixed_width_bit_packer_core (
   input  logic                               clock,
   input  logic                               reset,
   fwbp_stream_if.sink                        req_chan,
   fwbp_stream_if.source                      rsp_chan,
   input  logic                               csr_write_enable,
   input  fwbp_pkg::csr_index_type            csr_index,
   input  logic [fwbp_pkg::WordWidth-1:0]     csr_write_data
);

   // Configuration registers.
   logic [fwbp_pkg::FieldBits-1:0] field_width_ff, field_width_in;
   logic [fwbp_pkg::WordWidth-1:0] total_count_ff, total_count_in;

   // Input stage.
   logic                           s1_valid_ff, s1_valid_in;
   logic [fwbp_pkg::WordWidth-1:0] s1_value_ff, s1_value_in;

   // Packing state.
   logic [fwbp_pkg::WordWidth-1:0] partial_ff, partial_in;
   logic [fwbp_pkg::PosWidth-1:0]  bit_pos_ff, bit_pos_in;
   logic [fwbp_pkg::PosWidth-1:0]  group_idx_ff, group_idx_in;
   logic [fwbp_pkg::WordWidth-1:0] seen_ff, seen_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   fwbp_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                             out_free;
   logic                             s1_advance;
   logic                             req_accept;
   logic [fwbp_pkg::WordWidth-1:0]   packed_limit;
   logic [fwbp_pkg::FieldBits-1:0]   width_use;
   logic [fwbp_pkg::WordWidth-1:0]   value_mask;
   logic [fwbp_pkg::WordWidth-1:0]   value_masked;
   logic [2*fwbp_pkg::WordWidth-1:0] value_shifted;
   logic [fwbp_pkg::WordWidth-1:0]   merged;
   logic [fwbp_pkg::FieldBits-1:0]   pos_sum;
   logic                             group_last;
   logic                             emit;

   // The result register is free when empty or when its transaction leaves now.
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_accept = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      field_width_in = field_width_ff;
      total_count_in = total_count_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            fwbp_pkg::CsrFieldWidth: begin
               field_width_in = csr_write_data[fwbp_pkg::FieldBits-1:0];
            end
            fwbp_pkg::CsrTotalCount: begin
               total_count_in = csr_write_data;
            end
            default: begin
               field_width_in = field_width_ff;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_value_in = s1_value_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_value_in = req_chan.payload.value;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Datapath of one packing step.
   always_comb begin
      priority if (field_width_ff == '0) begin
         width_use = fwbp_pkg::FieldBits'(1);
      end else if (field_width_ff > fwbp_pkg::FieldBits'(fwbp_pkg::WordWidth)) begin
         width_use = fwbp_pkg::FieldBits'(fwbp_pkg::WordWidth);
      end else begin
         width_use = field_width_ff;
      end
      packed_limit  = {total_count_ff[fwbp_pkg::WordWidth-1:fwbp_pkg::PosWidth],
                       {fwbp_pkg::PosWidth{1'b0}}};
      value_mask    = {fwbp_pkg::WordWidth{1'b1}}
                      >> (fwbp_pkg::FieldBits'(fwbp_pkg::WordWidth) - width_use);
      value_masked  = s1_value_ff & value_mask;
      // The upper half holds the bits that spill into the next word.
      value_shifted = {{fwbp_pkg::WordWidth{1'b0}}, value_masked} << bit_pos_ff;
      merged        = partial_ff | value_shifted[fwbp_pkg::WordWidth-1:0];
      pos_sum       = {1'b0, bit_pos_ff} + width_use;
      group_last    = (group_idx_ff == {fwbp_pkg::PosWidth{1'b1}});
   end

   always_comb begin
      partial_in   = partial_ff;
      bit_pos_in   = bit_pos_ff;
      group_idx_in = group_idx_ff;
      seen_in      = seen_ff;
      emit         = 1'b0;
      rsp_data_in  = rsp_data_ff;
      if (s1_advance && (seen_ff < total_count_ff)) begin
         seen_in = seen_ff + fwbp_pkg::WordWidth'(1);
         if (seen_ff >= packed_limit) begin
            // Beyond the last full group the value goes out raw.
            emit                  = 1'b1;
            rsp_data_in.word      = s1_value_ff;
            rsp_data_in.is_tail   = 1'b1;
            rsp_data_in.group_end = 1'b0;
         end else begin
            group_idx_in          = group_idx_ff + fwbp_pkg::PosWidth'(1);
            rsp_data_in.word      = merged;
            rsp_data_in.is_tail   = 1'b0;
            rsp_data_in.group_end = group_last;
            if (group_last) begin
               // The group always ends aligned; spilled bits are dropped.
               emit       = 1'b1;
               partial_in = '0;
               bit_pos_in = '0;
            end else if (pos_sum > fwbp_pkg::FieldBits'(fwbp_pkg::WordWidth)) begin
               emit       = 1'b1;
               partial_in = value_shifted[2*fwbp_pkg::WordWidth-1:fwbp_pkg::WordWidth];
               bit_pos_in = pos_sum[fwbp_pkg::PosWidth-1:0];
            end else if (pos_sum == fwbp_pkg::FieldBits'(fwbp_pkg::WordWidth)) begin
               emit       = 1'b1;
               partial_in = '0;
               bit_pos_in = '0;
            end else begin
               partial_in = merged;
               bit_pos_in = pos_sum[fwbp_pkg::PosWidth-1:0];
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= fwbp_pkg::FieldBits'(fwbp_pkg::WordWidth);
         total_count_ff <= '0;
         s1_valid_ff    <= 1'b0;
         partial_ff     <= '0;
         bit_pos_ff     <= '0;
         group_idx_ff   <= '0;
         seen_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         field_width_ff <= field_width_in;
         total_count_ff <= total_count_in;
         s1_valid_ff    <= s1_valid_in;
         partial_ff     <= partial_in;
         bit_pos_ff     <= bit_pos_in;
         group_idx_ff   <= group_idx_in;
         seen_ff        <= seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_value_ff <= s1_value_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
